### rtl/ndrd_pkg.sv
// Shared types and constants for the data-run list decoder.
package ndrd_pkg;

    // Longest count or offset field a header may announce, in bytes.
    localparam int FIELD_BYTES = 8;

    // Accumulators are one 64-bit word: eight byte lanes.
    localparam int WORD_W     = 64;
    localparam int WORD_BYTES = WORD_W / 8;
    localparam int LANE_W     = 3;

    // Run queue between parser and executor (power of two, pointers wrap).
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One decoded run, or an error marker, as handed to the executor.
    typedef struct packed {
        logic              start;   // header byte opened a new list
        logic              err;     // bad header, list ends
        logic [WORD_W-1:0] total;   // clusters wanted, latched at list start
        logic [WORD_W-1:0] count;   // raw cluster count of the run
        logic [WORD_W-1:0] offset;  // sign-extended cluster offset
    } t_run_rec;

    // Queue status seen by both neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### rtl/ndrd_parser.sv
// Byte parser: splits headers, count and offset fields into run records.
module ndrd_parser import ndrd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_total,
    output logic              o_push,
    output t_run_rec          o_rec
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_COUNT  = 2'd1;
    localparam logic [1:0] PH_OFFSET = 2'd2;

    logic [1:0]        r_phase, n_phase;
    logic [3:0]        r_csize, n_csize;
    logic [3:0]        r_osize, n_osize;
    logic [3:0]        r_pos, n_pos;
    logic [WORD_W-1:0] r_count, n_count;
    logic [WORD_W-1:0] r_offset, n_offset;
    logic              r_start, n_start;
    logic [WORD_W-1:0] r_total, n_total;

    logic [1:0]        eff_phase;
    logic [3:0]        pos_inc;
    logic [WORD_W-1:0] count_ins;
    logic [WORD_W-1:0] offset_ins;
    logic [WORD_W-1:0] offset_fin;
    logic              hdr_err;

    always_comb begin
        count_ins  = r_count;
        offset_ins = r_offset;
        offset_fin = r_offset;
        for (int k = 0; k < WORD_BYTES; k++) begin
            if (r_pos[LANE_W-1:0] == LANE_W'(k)) begin
                count_ins[8*k +: 8]  = i_byte;
                offset_ins[8*k +: 8] = i_byte;
                offset_fin[8*k +: 8] = i_byte;
            end else if (LANE_W'(k) > r_pos[LANE_W-1:0] && i_byte[7]) begin
                // sign fill above the top byte of the field
                offset_fin[8*k +: 8] = 8'hff;
            end
        end
    end

    assign pos_inc   = r_pos + 4'd1;
    assign eff_phase = i_start ? PH_HEADER : r_phase;
    assign hdr_err   = (i_byte == 8'd0) || (i_byte[3:0] > 4'(FIELD_BYTES))
                       || (i_byte[7:4] > 4'(FIELD_BYTES));

    always_comb begin
        n_phase  = r_phase;
        n_csize  = r_csize;
        n_osize  = r_osize;
        n_pos    = r_pos;
        n_count  = r_count;
        n_offset = r_offset;
        n_start  = r_start;
        n_total  = r_total;
        o_push   = 1'b0;
        o_rec.start  = r_start;
        o_rec.err    = 1'b0;
        o_rec.total  = r_total;
        o_rec.count  = '0;
        o_rec.offset = '0;
        if (i_take) begin
            unique case (eff_phase)
                PH_HEADER: begin
                    n_start     = i_start;
                    o_rec.start = i_start;
                    if (i_start) begin
                        n_total     = i_total;
                        o_rec.total = i_total;
                    end
                    n_csize  = i_byte[3:0];
                    n_osize  = i_byte[7:4];
                    n_pos    = 4'd0;
                    n_count  = '0;
                    n_offset = '0;
                    if (hdr_err) begin
                        o_push    = 1'b1;
                        o_rec.err = 1'b1;
                        n_phase   = PH_HEADER;
                    end else if (i_byte[3:0] != 4'd0) begin
                        n_phase = PH_COUNT;
                    end else if (i_byte[7:4] != 4'd0) begin
                        n_phase = PH_OFFSET;
                    end else begin
                        o_push  = 1'b1;
                        n_phase = PH_HEADER;
                    end
                end
                PH_COUNT: begin
                    n_count = count_ins;
                    if (pos_inc >= r_csize) begin
                        n_pos = 4'd0;
                        if (r_osize != 4'd0) begin
                            n_phase = PH_OFFSET;
                        end else begin
                            o_push      = 1'b1;
                            o_rec.count = count_ins;
                            n_phase     = PH_HEADER;
                        end
                    end else begin
                        n_pos = pos_inc;
                    end
                end
                PH_OFFSET: begin
                    n_offset = offset_ins;
                    if (pos_inc >= r_osize) begin
                        o_push       = 1'b1;
                        o_rec.count  = r_count;
                        o_rec.offset = offset_fin;
                        n_pos        = 4'd0;
                        n_phase      = PH_HEADER;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_csize <= 4'd0;
            r_osize <= 4'd0;
            r_pos   <= 4'd0;
            r_start <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_csize <= n_csize;
            r_osize <= n_osize;
            r_pos   <= n_pos;
            r_start <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count  <= n_count;
        r_offset <= n_offset;
        r_total  <= n_total;
    end

endmodule

### rtl/ndrd_queue.sv
// Short run-record queue between parser and executor.
module ndrd_queue import ndrd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_run_rec i_wdata,
    input  logic     i_pop,
    output t_run_rec o_rdata,
    output t_q_stat  o_stat
);

    t_run_rec            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_rdata      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

### rtl/ndrd_exec.sv
// Run executor: running cluster address, remaining count, clipping, result register.
module ndrd_exec import ndrd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_run_rec          i_rec,
    input  t_q_stat           i_stat,
    output logic              o_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [WORD_W-1:0] o_lcn,
    output logic [WORD_W-1:0] o_clusters,
    output logic              o_last,
    output logic              o_err
);

    logic [WORD_W-1:0] r_addr, n_addr;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic              r_done, n_done;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_lcn, r_out_clusters;
    logic              r_out_last, r_out_err;

    logic              slot_free;
    logic [WORD_W-1:0] base_addr, base_rem, sum_addr, take;
    logic              base_done, clip;
    logic              emit;
    logic [WORD_W-1:0] emit_lcn, emit_clusters;
    logic              emit_last, emit_err;

    assign slot_free = !r_out_valid || i_out_ready;
    assign base_addr = i_rec.start ? '0 : r_addr;
    assign base_rem  = i_rec.start ? i_rec.total : r_rem;
    assign base_done = i_rec.start ? (i_rec.total == '0) : r_done;
    assign sum_addr  = base_addr + i_rec.offset;
    assign clip      = (i_rec.count >= base_rem);
    assign take      = clip ? base_rem : i_rec.count;

    // records for a finished list are dropped without waiting for the output
    assign o_pop = !i_stat.empty && (base_done || slot_free);

    always_comb begin
        n_addr        = r_addr;
        n_rem         = r_rem;
        n_done        = r_done;
        emit          = 1'b0;
        emit_lcn      = sum_addr;
        emit_clusters = take;
        emit_last     = clip;
        emit_err      = 1'b0;
        if (o_pop) begin
            n_addr = base_addr;
            n_rem  = base_rem;
            n_done = base_done;
            if (!base_done) begin
                emit = 1'b1;
                if (i_rec.err) begin
                    n_done        = 1'b1;
                    emit_lcn      = '0;
                    emit_clusters = '0;
                    emit_last     = 1'b1;
                    emit_err      = 1'b1;
                end else begin
                    n_addr = sum_addr;
                    n_rem  = base_rem - take;
                    n_done = clip;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_rem       <= '0;
            r_done      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_addr <= n_addr;
            r_rem  <= n_rem;
            r_done <= n_done;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_lcn      <= emit_lcn;
            r_out_clusters <= emit_clusters;
            r_out_last     <= emit_last;
            r_out_err      <= emit_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_lcn       = r_out_lcn;
    assign o_clusters  = r_out_clusters;
    assign o_last      = r_out_last;
    assign o_err       = r_out_err;

endmodule

### rtl/ntfs_data_run_decoder.sv
// Top level of the data-run list decoder: config register, parser, queue, executor.
//
//  channel | dir | handshake                     | payload
//  --------+-----+-------------------------------+------------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] run_byte; tuser[0] list_start
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata[63:0] run_lcn, [127:64] run_clusters;
//          |     |                               | tlast last; tuser[0] error
//  apb     | in  | psel, penable, pwrite, pready | 0x0: run_clusters_total (64 bit)
//
// One byte is taken per cycle while the run queue has room. A run's result is pushed
// into the run queue with its final byte, then moves on into the output register.
// The parser stalls only when the four-entry run queue is full, which happens only
// while m_axis is held off; bytes of a finished list drain without stalling.
// Synchronous active-low reset; afterwards the block is idle until a list_start item.
// run_clusters_total is sampled on the list_start header, so a write applies at the
// next list.
module ntfs_data_run_decoder import ndrd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // stream in
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] run_byte
    input  logic [0:0]    s_axis_tuser,   // [0] list_start
    // stream out
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // [63:0] run_lcn, [127:64] run_clusters
    output logic          m_axis_tlast,   // last
    output logic [0:0]    m_axis_tuser,   // [0] error
    // register port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    localparam logic REG_TOTAL = 1'b0;

    logic [WORD_W-1:0] r_total;
    logic              cfg_wr;

    logic              in_take;
    logic              push, pop;
    t_run_rec          wr_rec, rd_rec;
    t_q_stat           q_stat;

    logic [WORD_W-1:0] out_lcn, out_clusters;
    logic              out_err;

    // register port: always ready, 8-byte register slots
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[3] == REG_TOTAL);
    assign prdata = (paddr[3] == REG_TOTAL) ? r_total : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= WORD_W'(1);
        end else if (cfg_wr) begin
            r_total <= pwdata;
        end
    end

    // front side accepts whenever the queue has room
    assign s_axis_tready = !q_stat.full;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    ndrd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_take),
        .i_byte  (s_axis_tdata),
        .i_start (s_axis_tuser[0]),
        .i_total (r_total),
        .o_push  (push),
        .o_rec   (wr_rec)
    );

    ndrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wr_rec),
        .i_pop   (pop),
        .o_rdata (rd_rec),
        .o_stat  (q_stat)
    );

    ndrd_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rd_rec),
        .i_stat      (q_stat),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_lcn       (out_lcn),
        .o_clusters  (out_clusters),
        .o_last      (m_axis_tlast),
        .o_err       (out_err)
    );

    assign m_axis_tdata = {out_clusters, out_lcn};
    assign m_axis_tuser = out_err;

endmodule

### rtl/ndrd_checker.sv
// Port-level checks for the data-run list decoder, bound to the top level.
module ndrd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic         m_axis_tlast,
    input logic [0:0]   m_axis_tuser
);

    a_rst_out_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_rst_in_ready: assert property (@(posedge i_clk) !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("error result not marked last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0))
        else $error("error result carries nonzero run data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind ntfs_data_run_decoder ndrd_checker u_ndrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

### test/ntfs_data_run_decoder_tb.sv
// Self-checking testbench for the data-run list decoder: directed runs, then random lists.
module ntfs_data_run_decoder_tb import ndrd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Register map: one 64-bit register at byte address 0.
    localparam logic [3:0] REG_RUN_CLUSTERS_TOTAL = 4'h0;

    typedef enum logic [1:0] {PH_HEADER, PH_COUNT, PH_OFFSET} t_parse_phase;

    // One decoded run as it leaves the block.
    typedef struct packed {
        logic [63:0] lcn;
        logic [63:0] clusters;
        logic        last;
        logic        err;
    } t_run_result;

    // Tracks the run list byte by byte and holds the runs still owed by the block.
    class t_run_scoreboard;
        logic [63:0]  clusters_total = 64'd1;
        t_parse_phase parse_phase    = PH_HEADER;
        int           cnt_bytes      = 0;
        int           off_bytes      = 0;
        int           byte_idx       = 0;
        logic [63:0]  count_acc      = '0;
        logic [63:0]  offset_acc     = '0;
        logic [63:0]  cluster_addr   = '0;
        logic [63:0]  clusters_left  = '0;
        bit           list_idle      = 1'b1;
        t_run_result  pending_runs[$];
        int           mismatches     = 0;

        // Run complete: advance the address, clip the count, maybe end the list.
        function void close_run();
            t_run_result r;
            logic [63:0] take;
            cluster_addr += offset_acc;
            take = (count_acc < clusters_left) ? count_acc : clusters_left;
            clusters_left -= take;
            r.lcn      = cluster_addr;
            r.clusters = take;
            r.last     = (clusters_left == 64'd0);
            r.err      = 1'b0;
            if (r.last)
                list_idle = 1'b1;
            parse_phase = PH_HEADER;
            byte_idx    = 0;
            pending_runs.push_back(r);
        endfunction

        // Accepted byte; returns 0 when the block just drops it (list already done).
        function bit note_byte(logic [7:0] b, logic start);
            t_run_result r;
            if (start) begin
                cluster_addr  = '0;
                clusters_left = clusters_total;
                parse_phase   = PH_HEADER;
                byte_idx      = 0;
                list_idle     = (clusters_total == 64'd0);
            end
            if (list_idle)
                return start;
            case (parse_phase)
                PH_COUNT: begin
                    count_acc |= 64'(b) << (8 * byte_idx);
                    byte_idx++;
                    if (byte_idx >= cnt_bytes) begin
                        byte_idx = 0;
                        if (off_bytes > 0)
                            parse_phase = PH_OFFSET;
                        else
                            close_run();
                    end
                end
                PH_OFFSET: begin
                    offset_acc |= 64'(b) << (8 * byte_idx);
                    byte_idx++;
                    if (byte_idx >= off_bytes) begin
                        // sign-extend from the top byte of a short field
                        if (b[7] && off_bytes < 8)
                            offset_acc |= ~64'd0 << (8 * off_bytes);
                        close_run();
                    end
                end
                default: begin
                    cnt_bytes  = b[3:0];
                    off_bytes  = b[7:4];
                    byte_idx   = 0;
                    count_acc  = '0;
                    offset_acc = '0;
                    if (b == 8'h00 || cnt_bytes > FIELD_BYTES || off_bytes > FIELD_BYTES) begin
                        list_idle   = 1'b1;
                        parse_phase = PH_HEADER;
                        r = '{lcn: 64'd0, clusters: 64'd0, last: 1'b1, err: 1'b1};
                        pending_runs.push_back(r);
                    end else if (cnt_bytes > 0) begin
                        parse_phase = PH_COUNT;
                    end else if (off_bytes > 0) begin
                        parse_phase = PH_OFFSET;
                    end else begin
                        close_run();
                    end
                end
            endcase
            return 1'b1;
        endfunction

        // Compare one delivered run against the oldest one owed.
        function void check_result(t_run_result got);
            t_run_result want;
            if (pending_runs.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected run: lcn=%h clusters=%h last=%b error=%b",
                         $time, got.lcn, got.clusters, got.last, got.err);
                return;
            end
            want = pending_runs.pop_front();
            if (got.lcn !== want.lcn) begin
                mismatches++;
                $display("%0t: run_lcn expected %h actual %h", $time, want.lcn, got.lcn);
            end
            if (got.clusters !== want.clusters) begin
                mismatches++;
                $display("%0t: run_clusters expected %h actual %h",
                         $time, want.clusters, got.clusters);
            end
            if (got.last !== want.last) begin
                mismatches++;
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            end
            if (got.err !== want.err) begin
                mismatches++;
                $display("%0t: error expected %b actual %b", $time, want.err, got.err);
            end
        endfunction
    endclass

    // ---------------------------------------------------------------- DUT I/O
    logic          i_clk;
    logic          i_rst_n       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [7:0]    s_axis_tdata  = 8'h00;   // [7:0] run_byte
    logic [0:0]    s_axis_tuser  = 1'b0;    // [0] list_start
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [127:0]  m_axis_tdata;            // [63:0] run_lcn, [127:64] run_clusters
    logic          m_axis_tlast;            // last
    logic [0:0]    m_axis_tuser;            // [0] error
    logic          psel          = 1'b0;
    logic          penable       = 1'b0;
    logic          pwrite        = 1'b0;
    logic [3:0]    paddr         = 4'h0;
    logic [63:0]   pwdata        = '0;
    logic [63:0]   prdata;
    logic          pready;

    t_run_scoreboard sb;
    int            items_taken     = 0;   // bytes the block actually consumed
    int            sender_idle_pct = 0;
    int            recv_idle_pct   = 0;

    ntfs_data_run_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("FAIL ntfs_data_run_decoder");
        $finish;
    end

    // Receiver backpressure, redrawn every cycle.
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Inputs only move at posedge, so the handshake is stable at negedge and
    // the transfer completes at the following posedge.
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result('{lcn: m_axis_tdata[63:0], clusters: m_axis_tdata[127:64],
                              last: m_axis_tlast, err: m_axis_tuser[0]});
    end

    // ------------------------------------------------------------- drivers
    // Present one item; returns at the posedge where it was taken.
    task automatic send_byte(logic [7:0] b, logic start);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        @(negedge i_clk);
        while (!s_axis_tready)
            @(negedge i_clk);
        @(posedge i_clk);
        if (sb.note_byte(b, start))
            items_taken++;
    endtask

    // Drop valid, wait until every owed run is out, then let the pipe settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_runs.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // APB write: setup, access, done at the posedge with pready high.
    task automatic apb_write(logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_RUN_CLUSTERS_TOTAL;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready)
            @(negedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.clusters_total = value;
    endtask

    // One well-formed run with random field sizes and contents.
    task automatic send_random_run(bit open);
        int cnt_bytes;
        int off_bytes;
        int r;
        r = $urandom_range(0, 99);
        cnt_bytes = (r < 45) ? 1 : (r < 65) ? 2 : (r < 75) ? 0 : $urandom_range(3, 8);
        r = $urandom_range(0, 99);
        off_bytes = (r < 40) ? 1 : (r < 65) ? 2 : (r < 80) ? 3 :
                    (r < 88) ? 0 : $urandom_range(4, 8);
        if (cnt_bytes == 0 && off_bytes == 0)
            cnt_bytes = 1;
        send_byte({4'(off_bytes), 4'(cnt_bytes)}, open);
        repeat (cnt_bytes + off_bytes)
            send_byte(8'($urandom), 1'b0);
    endtask

    // Zero header, or a header with a field over eight bytes.
    function automatic logic [7:0] bad_header();
        case ($urandom_range(0, 2))
            0:       return 8'h00;
            1:       return {4'($urandom_range(9, 15)), 4'($urandom_range(0, 15))};
            default: return {4'($urandom_range(0, 15)), 4'($urandom_range(9, 15))};
        endcase
    endfunction

    // Mostly whole lists; some bad headers, cut-off runs and stray bytes.
    task automatic random_phase(int n_items, logic [63:0] total);
        int  goal;
        int  r;
        int  part_bytes;
        bit  reopen;
        bit  open;
        wait_drained();
        apb_write(total);
        goal   = items_taken + n_items;
        reopen = 1'b1;
        while (items_taken < goal) begin
            r      = $urandom_range(0, 99);
            open   = reopen || sb.list_idle || ($urandom_range(0, 99) < 3);
            reopen = 1'b0;
            if (r < 86) begin
                send_random_run(open);
            end else if (r < 91) begin
                send_byte(bad_header(), open);
            end else if (r < 95) begin
                // partial run, dropped by the restart that follows
                part_bytes = $urandom_range(2, 8);
                send_byte({4'($urandom_range(0, 8)), 4'(part_bytes)}, open);
                repeat ($urandom_range(1, part_bytes - 1))
                    send_byte(8'($urandom), 1'b0);
                reopen = 1'b1;
            end else begin
                send_byte(8'($urandom), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------- sequence
    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sender_idle_pct = 22;
        recv_idle_pct   = 62;

        // --- directed part
        @(posedge i_clk);
        apb_write(64'd1000);
        send_byte(8'h55, 1'b0);             // idle after reset: dropped
        // 1-byte count, 2-byte negative offset
        send_byte(8'h21, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        // no offset field: address unchanged
        send_byte(8'h01, 1'b0);
        send_byte(8'h05, 1'b0);
        // no count field: zero-length run
        send_byte(8'h10, 1'b0);
        send_byte(8'h7F, 1'b0);
        // new total while the list is open only applies at the next start
        wait_drained();
        apb_write(64'd1);
        send_byte(8'h22, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b1);             // restart mid-run on a zero header
        send_byte(8'h91, 1'b1);             // offset field too long
        send_byte(8'h01, 1'b1);             // count 0 keeps the one cluster wanted
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);             // count 255 clipped to 1, last
        send_byte(8'hFF, 1'b0);
        // zero total: start leaves the block idle
        wait_drained();
        apb_write(64'd0);
        send_byte(8'h31, 1'b1);
        send_byte(8'h01, 1'b0);
        // full-width count against the largest total
        wait_drained();
        apb_write(64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h08, 1'b1);
        repeat (8) send_byte(8'hFF, 1'b0);

        // --- random part, three backpressure modes
        random_phase(283, 64'($urandom_range(1, 3000)));
        sender_idle_pct = 62;
        recv_idle_pct   = 22;
        random_phase(283, 64'($urandom_range(1, 40)));
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        random_phase(283, {32'($urandom), 32'($urandom)});

        wait_drained();
        if (sb.mismatches == 0)
            $display("PASS ntfs_data_run_decoder");
        else
            $display("FAIL ntfs_data_run_decoder");
        $finish;
    end

endmodule

### sim.f
rtl/ndrd_pkg.sv
rtl/ndrd_parser.sv
rtl/ndrd_queue.sv
rtl/ndrd_exec.sv
rtl/ntfs_data_run_decoder.sv
rtl/ndrd_checker.sv
test/ntfs_data_run_decoder_tb.sv
